// File: hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/irnpsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irnpsd_pkg
// Types and constants shared by the ir pulse/space decoder.
// ----------------------------------------------------------------------------
package irnpsd_pkg;

  localparam int BYTE_W      = 8;
  localparam int NIB_W       = 4;
  localparam int DUR_W       = 24;
  localparam int SUM_W       = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DUR_W-1:0]     GAP_LIMIT_RST = 24'd15999999;
  localparam logic [DUR_W-1:0]     DUR_MAX       = 24'hFFFFFF;
  localparam logic [SUM_W-1:0]     SUM_MAX       = 32'hFFFFFFFF;
  localparam logic [NIB_W-1:0]     NIB_ESC       = 4'hF;
  localparam logic [BYTE_W-1:0]    BYTE_IDLE     = 8'hFF;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 1'b0;

  // one decoded byte as handed from the front to the back
  typedef struct packed {
    logic              pulse_en;
    logic [BYTE_W-1:0] pulse_code;
    logic              space_en;
    logic [BYTE_W-1:0] space_code;
    logic              set_idle;
  } cmd_t;

endpackage

// File: hdl/irnpsd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irnpsd_in_if
// Input channel: received byte with its microsecond timestamp.
// ----------------------------------------------------------------------------
interface irnpsd_in_if #(
  parameter int TIME_WIDTH = 40
);
  logic                              valid;
  logic                              ready;
  logic [irnpsd_pkg::BYTE_W-1:0]     rx_byte;
  logic [TIME_WIDTH-1:0]             now_us;

  modport source (output valid, output rx_byte, output now_us, input ready);
  modport sink   (input valid, input rx_byte, input now_us, output ready);
endinterface

// File: hdl/irnpsd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irnpsd_out_if
// Result channel: one pulse, space or leading gap duration per beat.
// ----------------------------------------------------------------------------
interface irnpsd_out_if;
  logic                         valid;
  logic                         ready;
  logic [irnpsd_pkg::DUR_W-1:0] duration_us;
  logic                         is_pulse;
  logic                         last;

  modport source (output valid, output duration_us, output is_pulse, output last,
                  input ready);
  modport sink   (input valid, input duration_us, input is_pulse, input last,
                  output ready);
endinterface

// File: hdl/irnpsd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irnpsd_queue
// Short command queue between the byte decoder and the result sequencer.
// ----------------------------------------------------------------------------
module irnpsd_queue #(
  parameter int TIME_WIDTH = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  irnpsd_pkg::cmd_t      push_cmd,
  input  logic [TIME_WIDTH-1:0] push_now,
  output logic                  full,
  input  logic                  pop,
  output logic                  valid,
  output irnpsd_pkg::cmd_t      pop_cmd,
  output logic [TIME_WIDTH-1:0] pop_now
);
  localparam int DEPTH = irnpsd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  irnpsd_pkg::cmd_t      cmd_mem [DEPTH];
  logic [TIME_WIDTH-1:0] now_mem [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r;
  logic [PTR_W-1:0]      rd_ptr_r;
  logic [CNT_W-1:0]      count_r;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_cmd = cmd_mem[rd_ptr_r];
  assign pop_now = now_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_mem[wr_ptr_r] <= push_cmd;
      now_mem[wr_ptr_r] <= push_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end
endmodule

// File: hdl/irnpsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irnpsd_front
// Byte decoder: tracks the escape phase and turns each byte into a command.
// ----------------------------------------------------------------------------
module irnpsd_front #(
  parameter int TIME_WIDTH = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  irnpsd_in_if.sink             in_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output irnpsd_pkg::cmd_t      q_cmd,
  output logic [TIME_WIDTH-1:0] q_now
);
  typedef enum logic [1:0] {
    PH_PULSE_SPACE,
    PH_FULL_PULSE,
    PH_FULL_SPACE,
    PH_IGNORE_PULSE
  } phase_t;

  phase_t                          phase_r;
  phase_t                          phase_nxt;
  irnpsd_pkg::cmd_t                cmd;
  logic                            accept;
  logic [irnpsd_pkg::NIB_W-1:0]    hi_nib;
  logic [irnpsd_pkg::NIB_W-1:0]    lo_nib;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign hi_nib      = in_ch.rx_byte[irnpsd_pkg::BYTE_W-1:irnpsd_pkg::NIB_W];
  assign lo_nib      = in_ch.rx_byte[irnpsd_pkg::NIB_W-1:0];

  always_comb begin
    cmd       = '0;
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_PULSE_SPACE: begin
        if (hi_nib == irnpsd_pkg::NIB_ESC) begin
          phase_nxt = PH_FULL_PULSE;
        end else begin
          cmd.pulse_en   = 1'b1;
          cmd.pulse_code = irnpsd_pkg::BYTE_W'(hi_nib);
          if (lo_nib == irnpsd_pkg::NIB_ESC) begin
            phase_nxt = PH_FULL_SPACE;
          end else begin
            cmd.space_en   = 1'b1;
            cmd.space_code = irnpsd_pkg::BYTE_W'(lo_nib);
          end
        end
      end
      PH_FULL_PULSE: begin
        cmd.pulse_en   = 1'b1;
        cmd.pulse_code = in_ch.rx_byte;
        phase_nxt      = PH_IGNORE_PULSE;
      end
      PH_FULL_SPACE: begin
        // full space of all ones is the idle marker
        if (in_ch.rx_byte == irnpsd_pkg::BYTE_IDLE) begin
          cmd.set_idle = 1'b1;
        end else begin
          cmd.space_en   = 1'b1;
          cmd.space_code = in_ch.rx_byte;
        end
        phase_nxt = PH_PULSE_SPACE;
      end
      PH_IGNORE_PULSE: begin
        if (lo_nib == irnpsd_pkg::NIB_ESC) begin
          phase_nxt = PH_FULL_SPACE;
        end else begin
          cmd.space_en   = 1'b1;
          cmd.space_code = irnpsd_pkg::BYTE_W'(lo_nib);
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // escape bytes carry nothing for the back end
  assign q_push = accept && (cmd.pulse_en || cmd.space_en || cmd.set_idle);
  assign q_cmd  = cmd;
  assign q_now  = in_ch.now_us;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PULSE_SPACE;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end
endmodule

// File: hdl/irnpsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irnpsd_back
// Result sequencer: leading gap, pulse and space durations, one per beat.
// ----------------------------------------------------------------------------
module irnpsd_back #(
  parameter int RESOLUTION_US = 256,
  parameter int TIME_WIDTH    = 40
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [irnpsd_pkg::DUR_W-1:0] gap_limit,
  input  logic                         q_valid,
  input  irnpsd_pkg::cmd_t             q_cmd,
  input  logic [TIME_WIDTH-1:0]        q_now,
  output logic                         q_pop,
  irnpsd_out_if.source                 out_ch
);
  localparam int DUR_W = irnpsd_pkg::DUR_W;
  localparam int SUM_W = irnpsd_pkg::SUM_W;
  localparam int HALF  = RESOLUTION_US / 2;

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_ELAPSE,
    ST_GAP,
    ST_PULSE,
    ST_SPACE
  } state_t;

  state_t                state_r;
  irnpsd_pkg::cmd_t      cmd_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [TIME_WIDTH-1:0] start_r;
  logic [TIME_WIDTH-1:0] elapsed_r;
  logic [SUM_W-1:0]      sum_r;
  logic                  idle_r;
  logic                  seen_r;
  logic                  out_valid_r;
  logic [DUR_W-1:0]      out_dur_r;
  logic                  out_pulse_r;
  logic                  out_last_r;

  logic                  slot_free;
  logic                  emit;
  logic [irnpsd_pkg::BYTE_W-1:0] code;
  logic [DUR_W-1:0]      dur;
  logic [SUM_W:0]        sum_add;
  logic [SUM_W-1:0]      sum_sat;
  logic [DUR_W-1:0]      gap;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_pop     = (state_r == ST_FETCH) && q_valid;
  // a beat is loaded into the output register in any result state with room
  assign emit      = slot_free && ((state_r == ST_GAP) || (state_r == ST_PULSE) ||
                                   (state_r == ST_SPACE));

  // code*res + res/2 stays well inside 24 bits at the default resolution of 256
  assign code    = (state_r == ST_PULSE) ? cmd_r.pulse_code : cmd_r.space_code;
  assign dur     = DUR_W'(code) * DUR_W'(RESOLUTION_US) + DUR_W'(HALF);
  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(dur);
  assign sum_sat = sum_add[SUM_W] ? irnpsd_pkg::SUM_MAX : sum_add[SUM_W-1:0];

  // elapsed is at most the limit here, so the low bits give the exact gap
  always_comb begin
    priority if (!seen_r || (elapsed_r > TIME_WIDTH'(gap_limit))) begin
      gap = irnpsd_pkg::DUR_MAX;
    end else if (elapsed_r < TIME_WIDTH'(sum_r)) begin
      gap = '0;
    end else begin
      gap = elapsed_r[DUR_W-1:0] - sum_r[DUR_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.duration_us = out_dur_r;
  assign out_ch.is_pulse    = out_pulse_r;
  assign out_ch.last        = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FETCH;
      out_valid_r <= 1'b0;
      idle_r      <= 1'b1;
      seen_r      <= 1'b0;
      sum_r       <= '0;
      start_r     <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_FETCH: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            now_r <= q_now;
            priority if (q_cmd.set_idle) begin
              idle_r <= 1'b1;
            end else if (q_cmd.pulse_en && idle_r) begin
              state_r <= ST_ELAPSE;
            end else if (q_cmd.pulse_en) begin
              state_r <= ST_PULSE;
            end else begin
              state_r <= ST_SPACE;
            end
          end
        end
        ST_ELAPSE: begin
          elapsed_r <= now_r - start_r;
          state_r   <= ST_GAP;
        end
        ST_GAP: begin
          if (slot_free) begin
            out_dur_r   <= gap;
            out_pulse_r <= 1'b0;
            out_last_r  <= 1'b0;
            start_r     <= now_r;
            seen_r      <= 1'b1;
            idle_r      <= 1'b0;
            sum_r       <= '0;
            state_r     <= ST_PULSE;
          end
        end
        ST_PULSE: begin
          if (slot_free) begin
            out_dur_r   <= dur;
            out_pulse_r <= 1'b1;
            out_last_r  <= !cmd_r.space_en;
            sum_r       <= sum_sat;
            state_r     <= cmd_r.space_en ? ST_SPACE : ST_FETCH;
          end
        end
        ST_SPACE: begin
          if (slot_free) begin
            out_dur_r   <= dur;
            out_pulse_r <= 1'b0;
            out_last_r  <= 1'b1;
            sum_r       <= sum_sat;
            state_r     <= ST_FETCH;
          end
        end
        default: state_r <= ST_FETCH;
      endcase
    end
  end
endmodule

// File: hdl/ir_nibble_pulse_space_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_nibble_pulse_space_decoder_unit
// Decodes nibble coded ir receiver bytes into pulse, space and gap durations.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the two-entry command queue has room;
// escape bytes end in the decoder and cost the back end nothing. The result
// sequencer fetches a command, forms the elapsed time ahead of a leading gap,
// then loads each result beat in turn (the idle marker needs only the fetch),
// and fetches the next command only once the last one's beats are loaded.
// Results leave through a single output register at up to one beat per cycle
// while the receiver is ready.
// gap_limit_us sits at byte address 0 of the cfg port and resets to 15999999.
module ir_nibble_pulse_space_decoder_unit #(
  parameter int RESOLUTION_US = 256,
  parameter int TIME_WIDTH    = 40
) (
  input  logic                              clk,
  input  logic                              rst_n,
  irnpsd_in_if.sink                         in_ch,
  irnpsd_out_if.source                      out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [irnpsd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [irnpsd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [irnpsd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                              cfg_pready
);
`include "assert_macros.svh"

  localparam int DUR_W = irnpsd_pkg::DUR_W;

  logic [DUR_W-1:0]                   gap_limit_r;
  logic [irnpsd_pkg::CFG_IDX_W-1:0]   cfg_idx;
  logic                               cfg_wr;

  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  irnpsd_pkg::cmd_t      q_in_cmd;
  irnpsd_pkg::cmd_t      q_out_cmd;
  logic [TIME_WIDTH-1:0] q_in_now;
  logic [TIME_WIDTH-1:0] q_out_now;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[irnpsd_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_idx == irnpsd_pkg::REG_GAP_LIMIT) ?
                      irnpsd_pkg::CFG_DATA_W'(gap_limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= irnpsd_pkg::GAP_LIMIT_RST;
    end else if (cfg_wr && (cfg_idx == irnpsd_pkg::REG_GAP_LIMIT)) begin
      gap_limit_r <= cfg_pwdata[DUR_W-1:0];
    end
  end

  irnpsd_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in_cmd),
    .q_now  (q_in_now)
  );

  irnpsd_queue #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .push_now (q_in_now),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_out_cmd),
    .pop_now  (q_out_now)
  );

  irnpsd_back #(
    .RESOLUTION_US (RESOLUTION_US),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .gap_limit (gap_limit_r),
    .q_valid   (q_valid),
    .q_cmd     (q_out_cmd),
    .q_now     (q_out_now),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

  `ASSERT_IMPLIES(a_no_push_when_full, clk, rst_n, q_push, !q_full, "push into full queue")
  `ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst_n, q_pop, q_valid, "pop from empty queue")
  `ASSERT_ALWAYS(a_push_only_on_beat, clk, rst_n, !q_push || (in_ch.valid && in_ch.ready), "push without input beat")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ir nibble pulse/space decoder unit.
// ----------------------------------------------------------------------------
// A queue of received bytes with timestamps feeds a clocked driver. On every
// accepted input beat a behavioural decoder works out the pulse, space and
// leading gap beats that byte should give. A clocked monitor compares each
// result beat field by field against the oldest one. A directed run comes
// first, then random pulse/space bursts with some noise bytes mixed in. The
// gap limit is rewritten between phases, and the idling of both sides
// is set anew for each random phase.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int BYTE_W     = irnpsd_pkg::BYTE_W;
  localparam int NIB_W      = irnpsd_pkg::NIB_W;
  localparam int DUR_W      = irnpsd_pkg::DUR_W;
  localparam int SUM_W      = irnpsd_pkg::SUM_W;
  localparam int CFG_DATA_W = irnpsd_pkg::CFG_DATA_W;
  localparam int CFG_ADDR_W = irnpsd_pkg::CFG_ADDR_W;

  localparam logic [DUR_W-1:0]  DUR_MAX       = irnpsd_pkg::DUR_MAX;
  localparam logic [DUR_W-1:0]  GAP_LIMIT_RST = irnpsd_pkg::GAP_LIMIT_RST;
  localparam logic [SUM_W-1:0]  SUM_MAX       = irnpsd_pkg::SUM_MAX;
  localparam logic [NIB_W-1:0]  NIB_ESC       = irnpsd_pkg::NIB_ESC;
  localparam logic [BYTE_W-1:0] BYTE_IDLE     = irnpsd_pkg::BYTE_IDLE;

  localparam int TIME_W       = 40;
  localparam int RES_US       = 256;
  localparam int CLK_PERIOD   = 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [CFG_ADDR_W-1:0] GAP_LIMIT_ADDR =
    CFG_ADDR_W'(irnpsd_pkg::REG_GAP_LIMIT) << 2;
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR     = GAP_LIMIT_ADDR + CFG_ADDR_W'(4);

  typedef enum logic [1:0] {
    PH_PAIR,
    PH_FULL_PULSE,
    PH_FULL_SPACE,
    PH_SKIP_PULSE
  } dec_phase_t;

  typedef struct packed {
    logic [DUR_W-1:0] dur;
    logic             pulse;
    logic             last;
  } beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic [TIME_W-1:0] now;
  } rx_item_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  irnpsd_in_if #(.TIME_WIDTH(TIME_W)) in_ch ();
  irnpsd_out_if                       out_ch ();

  ir_nibble_pulse_space_decoder_unit #(
    .RESOLUTION_US(RES_US),
    .TIME_WIDTH   (TIME_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // decoder state as the block should hold it
  logic [DUR_W-1:0]  lim_us;
  dec_phase_t        dec_phase;
  logic              line_idle;
  logic [SUM_W-1:0]  dur_sum;
  logic [TIME_W-1:0] sig_start;
  logic              start_seen;

  beat_t       pend_beat [3];
  int unsigned pend_n;
  beat_t       beat_q [$];

  rx_item_t    byte_q [$];
  int unsigned n_queued;
  logic [TIME_W-1:0] t_now;
  logic [TIME_W-1:0] t_sig;

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  // --------------------------------------------------------------------------
  // expected beats
  // --------------------------------------------------------------------------
  function automatic void add_beat(logic [DUR_W-1:0] d, logic p);
    pend_beat[pend_n] = '{dur: d, pulse: p, last: 1'b0};
    pend_n++;
  endfunction

  function automatic logic [DUR_W-1:0] code_len(logic [BYTE_W-1:0] c);
    return DUR_W'(int'(c) * RES_US + RES_US / 2);
  endfunction

  function automatic void add_len(logic [DUR_W-1:0] d);
    logic [SUM_W:0] s;
    s = {1'b0, dur_sum} + (SUM_W+1)'(d);
    dur_sum = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic void pulse_beat(logic [BYTE_W-1:0] c, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] el;
    logic [DUR_W-1:0]  gap;
    if (line_idle) begin
      // elapsed time wraps with the timestamp width
      el = now - sig_start;
      if (!start_seen || el > TIME_W'(lim_us))
        gap = DUR_MAX;
      else if (el < TIME_W'(dur_sum))
        gap = '0;
      else if (el - TIME_W'(dur_sum) > TIME_W'(DUR_MAX))
        gap = DUR_MAX;
      else
        gap = DUR_W'(el - TIME_W'(dur_sum));
      add_beat(gap, 1'b0);
      sig_start  = now;
      start_seen = 1'b1;
      line_idle  = 1'b0;
      dur_sum    = '0;
    end
    add_len(code_len(c));
    add_beat(code_len(c), 1'b1);
  endfunction

  function automatic void space_beat(logic [BYTE_W-1:0] c);
    add_len(code_len(c));
    add_beat(code_len(c), 1'b0);
  endfunction

  function automatic void decode_byte(logic [BYTE_W-1:0] b, logic [TIME_W-1:0] now);
    logic [NIB_W-1:0] hi;
    logic [NIB_W-1:0] lo;
    beat_t            bt;
    hi = b[7:4];
    lo = b[3:0];
    pend_n = 0;
    case (dec_phase)
      PH_PAIR: begin
        if (hi == NIB_ESC) begin
          dec_phase = PH_FULL_PULSE;
        end else begin
          pulse_beat(BYTE_W'(hi), now);
          if (lo == NIB_ESC)
            dec_phase = PH_FULL_SPACE;
          else
            space_beat(BYTE_W'(lo));
        end
      end
      PH_FULL_PULSE: begin
        pulse_beat(b, now);
        dec_phase = PH_SKIP_PULSE;
      end
      PH_FULL_SPACE: begin
        if (b == BYTE_IDLE)
          line_idle = 1'b1;
        else
          space_beat(b);
        dec_phase = PH_PAIR;
      end
      default: begin
        // pulse nibble ignored until an escape leads to a full space
        if (lo == NIB_ESC)
          dec_phase = PH_FULL_SPACE;
        else
          space_beat(BYTE_W'(lo));
      end
    endcase
    for (int i = 0; i < int'(pend_n); i++) begin
      bt = pend_beat[i];
      bt.last = (i == int'(pend_n) - 1);
      beat_q.push_back(bt);
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic logic [NIB_W-1:0] rnib(int unsigned top);
    return NIB_W'($urandom_range(0, top));
  endfunction

  function automatic logic [BYTE_W-1:0] rbyte(int unsigned top);
    return BYTE_W'($urandom_range(0, top));
  endfunction

  function automatic logic [TIME_W-1:0] adv_for(bit lead);
    return lead ? TIME_W'(0) : TIME_W'($urandom_range(0, 3000));
  endfunction

  function automatic void put_item(logic [BYTE_W-1:0] b, logic [TIME_W-1:0] now);
    byte_q.push_back('{rx: b, now: now});
    n_queued++;
  endfunction

  function automatic void put_at(logic [BYTE_W-1:0] b, logic [TIME_W-1:0] adv);
    t_now = t_now + adv;
    put_item(b, t_now);
  endfunction

  // where the next burst starts relative to the last one
  function automatic void pick_start();
    case ($urandom_range(0, 9))
      0:       t_now = t_sig + TIME_W'(lim_us);
      1:       t_now = t_sig + TIME_W'(lim_us) + TIME_W'(1);
      2:       t_now = TIME_W'({$urandom, $urandom});
      3:       t_now = t_sig + TIME_W'($urandom_range(0, 2000));
      4:       t_now = t_sig - TIME_W'($urandom_range(1, 1000));
      default: t_now = t_now + TIME_W'($urandom_range(0, 200000));
    endcase
    t_sig = t_now;
  endfunction

  function automatic void queue_burst();
    int unsigned n;
    int unsigned sel;
    bit          lead;
    bit          fin;
    pick_start();
    n = $urandom_range(1, 8);
    for (int k = 0; k < int'(n); k++) begin
      lead = (k == 0);
      fin  = (k == int'(n) - 1);
      sel  = $urandom_range(0, 9);
      if (sel == 0) begin
        put_at({NIB_ESC, rnib(15)}, adv_for(lead));
        put_at(rbyte(255), adv_for(lead));
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) put_at({rnib(15), rnib(14)}, adv_for(0));
        put_at({rnib(15), NIB_ESC}, adv_for(0));
        put_at(fin ? BYTE_IDLE : rbyte(254), adv_for(0));
      end else if (sel == 1) begin
        put_at({rnib(14), NIB_ESC}, adv_for(lead));
        put_at(fin ? BYTE_IDLE : rbyte(254), adv_for(0));
      end else begin
        put_at({rnib(14), rnib(14)}, adv_for(lead));
        if (fin) begin
          put_at({rnib(14), NIB_ESC}, adv_for(0));
          put_at(BYTE_IDLE, adv_for(0));
        end
      end
    end
  endfunction

  function automatic void queue_random(int unsigned count);
    int unsigned goal;
    goal = n_queued + count;
    while (n_queued < goal) begin
      if ($urandom_range(0, 99) < 85)
        queue_burst();
      else
        repeat ($urandom_range(1, 3)) put_at(rbyte(255), adv_for(0));
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk); while (byte_q.size() != 0 || in_ch.valid || beat_q.size() != 0);
    // escape and idle bytes give no beat and may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idle(int unsigned snd, int unsigned rcv);
    @(negedge clk);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == GAP_LIMIT_ADDR)
      lim_us = data[DUR_W-1:0];
  endtask

  // --------------------------------------------------------------------------
  // driver, receiver, monitor, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        void'(byte_q.pop_front());
      if (in_ch.valid && !in_ch.ready) begin
        // beat still on offer, hold it
      end else if (byte_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= byte_q[0].rx;
        in_ch.now_us  <= byte_q[0].now;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        decode_byte(in_ch.rx_byte, in_ch.now_us);
      if (out_ch.valid && out_ch.ready) begin
        if (beat_q.size() == 0) begin
          $error("unexpected result beat: duration_us %0d", out_ch.duration_us);
          err_cnt++;
        end else begin
          want = beat_q.pop_front();
          if (out_ch.duration_us !== want.dur) begin
            $error("duration_us: expected %0d, got %0d", want.dur, out_ch.duration_us);
            err_cnt++;
          end
          if (out_ch.is_pulse !== want.pulse) begin
            $error("is_pulse: expected %0b, got %0b", want.pulse, out_ch.is_pulse);
            err_cnt++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("ir_nibble_pulse_space_decoder_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.now_us  = '0;
    out_ch.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    snd_idle_pct  = 37;
    rcv_idle_pct  = 88;
    hold_req      = 1'b0;
    hold_left     = 0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    n_queued      = 0;
    t_now         = '0;
    t_sig         = '0;
    lim_us        = GAP_LIMIT_RST;
    dec_phase     = PH_PAIR;
    line_idle     = 1'b1;
    dur_sum       = '0;
    sig_start     = '0;
    start_seen    = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // first burst after reset, pairs, full codes both ways, ignored pulse nibble
    put_item(8'h00, 40'd0);
    put_item(8'hEE, 40'd300);
    put_item(8'h3F, 40'd4000);
    put_item(8'hFE, 40'd5000);
    put_item(8'hF5, 40'd70000);
    put_item(8'hFF, 40'd70000);
    put_item(8'h47, 40'd140000);
    put_item(8'h2F, 40'd142000);
    put_item(8'hFF, 40'd142000);
    // elapsed exactly at the limit, then one past it
    put_item(8'h12, 40'd15999999);
    put_item(8'h1F, 40'd16001000);
    put_item(8'hFF, 40'd16002000);
    put_item(8'h00, 40'd31999999);
    put_item(8'h0F, 40'd32000100);
    put_item(8'hFF, 40'd32000200);
    // no time passed since the last start: gap clamps to zero
    put_item(8'h55, 40'd31999999);
    put_item(8'h5F, 40'd31999999);
    put_item(8'hFF, 40'd31999999);
    // timestamp wraps between two bursts
    put_item(8'h11, 40'hFF_FFFF_FF00);
    put_item(8'h1F, 40'hFF_FFFF_FF00);
    put_item(8'hFF, 40'hFF_FFFF_FF00);
    put_item(8'h22, 40'h00_0000_1000);
    put_item(8'h2F, 40'h00_0000_1000);
    put_item(8'hFF, 40'h00_0000_1000);
    // escaped pulse straight out of idle
    put_item(8'hF0, 40'h00_0000_9000);
    put_item(8'h00, 40'h00_0000_9000);
    put_item(8'hAF, 40'h00_0000_9400);
    put_item(8'hFF, 40'h00_0000_9400);
    t_now = 40'h00_0000_9400;
    t_sig = 40'h00_0000_9000;
    wait_idle();

    cfg_write(GAP_LIMIT_ADDR, {8'($urandom), 24'd16777214});
    set_idle(37, 88);
    queue_random(160);
    wait_idle();

    cfg_write(GAP_LIMIT_ADDR, 32'd1);
    set_idle(88, 37);
    queue_random(80);
    // sender rests here until every beat is back
    wait_idle();
    cfg_write(GAP_LIMIT_ADDR, 32'($urandom_range(2000, 400000)));
    set_idle(88, 37);
    queue_random(80);
    wait_idle();

    cfg_write(SPARE_ADDR, $urandom);
    cfg_write(GAP_LIMIT_ADDR, 32'd20000);
    set_idle(0, 0);
    queue_random(110);
    // long receiver stall while the sender keeps offering
    hold_req = 1'b1;
    wait_idle();

    if (err_cnt == 0) begin
      $display("ir_nibble_pulse_space_decoder_unit verification clean");
    end else begin
      $display("ir_nibble_pulse_space_decoder_unit verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/irnpsd_pkg.sv
hdl/irnpsd_in_if.sv
hdl/irnpsd_out_if.sv
hdl/irnpsd_queue.sv
hdl/irnpsd_front.sv
hdl/irnpsd_back.sv
hdl/ir_nibble_pulse_space_decoder_unit.sv
tb/tb_top.sv
